FILE: rtl/core/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int OFF_W  = 12;
    localparam int STAT_W = 2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

    typedef struct packed {
        logic    init_wr;
        logic    start;
        logic    rd_at;
        logic    latch_cur;
        logic    advance;
        logic    wr_alloc;
        logic    wr_split;
        logic    rd_nx;
        logic    merge_nx;
        logic    wr_at_free;
        logic    wr_prev;
        logic    res_we;
        t_status res_status;
        logic    res_off;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic walk_end;
        logic fit;
        logic split;
        logic match;
        logic cur_used;
        logic nx_in;
        logic nx_free;
        logic prev_merge;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/core/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator with coalescing over a byte arena of block headers.
// ----------------------------------------------------------------------------
// The slave channel takes one request item: tuser selects allocate or free,
// tdata carries the requested size and the data offset to free. The master
// channel returns one result item per request with the data offset and a
// status of ok, no space or invalid free.
// Each request walks the block headers in address order through one
// header memory with separate write and registered read ports, reading
// and then examining each block visited. An allocate writes the chosen
// header, and one more when the block is split. A free does the lookup, a
// read of the following header and up to two header writes for the merges.
// One request is in work at a time; a finished result sits in the output
// register, so the next request is accepted while that result waits.
// After reset the block writes the single free block at offset zero in
// S_INIT and then accepts requests. If the receiver stalls, a finished
// request holds in the done state until the output register frees up.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top
    import ffba_pkg::*;
#(
    parameter int ARENA_BYTES  = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // request_size[11:0], block_address[23:12]
    input  logic        s_axis_tuser,  // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // data_offset[11:0], status[13:12], zero
);

    t_cmd             cmd;
    t_sts             sts;
    logic [OFF_W-1:0] out_offset;
    t_status          out_status;

    ffba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    ffba_dp #(
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_func    (s_axis_tuser),
        .i_want    (s_axis_tdata[11:0]),
        .i_addr    (s_axis_tdata[23:12]),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_offset  (out_offset),
        .o_status  (out_status)
    );

    assign m_axis_tdata = {2'b00, out_status, out_offset};

endmodule

FILE: rtl/core/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ffba_dp.sv
// ----------------------------------------------------------------------------
// ffba_dp
// Datapath: header memory, walk pointers, header arithmetic and result
// registers of the allocator.
// ----------------------------------------------------------------------------
module ffba_dp
    import ffba_pkg::*;
#(
    parameter int ARENA_BYTES  = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_func,
    input  logic [OFF_W-1:0] i_want,
    input  logic [OFF_W-1:0] i_addr,
    input  logic             i_m_ready,
    output logic             o_m_valid,
    output logic [OFF_W-1:0] o_offset,
    output t_status          o_status
);

    localparam int SW = $clog2(ARENA_BYTES);
    localparam int AW = SW + 1;
    localparam int DW = SW + 1;
    localparam int CW = (SW > OFF_W) ? SW : OFF_W;
    localparam int MW = (AW > OFF_W) ? AW : OFF_W;

    logic             r_func;
    logic [OFF_W-1:0] r_want;
    logic [OFF_W-1:0] r_addr;
    logic [AW-1:0]    r_at;
    logic [AW-1:0]    r_prev;
    logic             r_has_prev;
    logic [SW-1:0]    r_prev_size;
    logic             r_prev_used;
    logic [SW-1:0]    r_cur_size;
    logic [OFF_W-1:0] r_res_offset;
    t_status          r_res_status;
    logic             r_out_valid;
    logic [OFF_W-1:0] r_out_offset;
    t_status          r_out_status;

    logic [DW-1:0]    w_rdata;
    logic             rd_used;
    logic [SW-1:0]    rd_size;
    logic [AW-1:0]    at_hdr;
    logic [AW-1:0]    next_at;
    logic [AW-1:0]    cur_next;
    logic [SW-1:0]    rest;
    logic             we;
    logic [SW-1:0]    waddr;
    logic [DW-1:0]    wdata;
    logic [SW-1:0]    raddr;

    assign rd_used  = w_rdata[SW];
    assign rd_size  = w_rdata[SW-1:0];
    assign at_hdr   = r_at + AW'(HEADER_BYTES);
    assign next_at  = at_hdr + AW'(rd_size);
    assign cur_next = at_hdr + AW'(r_cur_size);
    assign rest     = rd_size - SW'(r_want);

    always_comb begin
        o_sts.is_free    = (r_func == FUNC_FREE);
        o_sts.walk_end   = (at_hdr > AW'(ARENA_BYTES));
        o_sts.fit        = !rd_used && (CW'(rd_size) >= CW'(r_want));
        o_sts.split      = (rest >= SW'(HEADER_BYTES + 1));
        o_sts.match      = (MW'(at_hdr) == MW'(r_addr));
        o_sts.cur_used   = rd_used;
        o_sts.nx_in      = (cur_next < AW'(ARENA_BYTES));
        o_sts.nx_free    = !rd_used;
        o_sts.prev_merge = r_has_prev && !r_prev_used;
        o_sts.out_free   = !r_out_valid || i_m_ready;
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_at[SW-1:0];
        wdata = {1'b0, r_cur_size};
        if (i_cmd.init_wr) begin
            we    = 1'b1;
            waddr = '0;
            wdata = {1'b0, SW'(ARENA_BYTES - HEADER_BYTES)};
        end else if (i_cmd.wr_alloc) begin
            we    = 1'b1;
            wdata = {1'b1, (o_sts.split ? SW'(r_want) : rd_size)};
        end else if (i_cmd.wr_split) begin
            we    = 1'b1;
            waddr = SW'(at_hdr + AW'(r_want));
            wdata = {1'b0, r_cur_size - SW'(r_want) - SW'(HEADER_BYTES)};
        end else if (i_cmd.wr_at_free) begin
            we    = 1'b1;
        end else if (i_cmd.wr_prev) begin
            we    = 1'b1;
            waddr = r_prev[SW-1:0];
            wdata = {1'b0, r_prev_size + SW'(HEADER_BYTES) + r_cur_size};
        end
    end

    assign raddr = i_cmd.rd_nx ? cur_next[SW-1:0] : r_at[SW-1:0];

    ffba_ram #(
        .WIDTH (DW),
        .DEPTH (ARENA_BYTES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func <= i_func;
            r_want <= i_want;
            r_addr <= i_addr;
            r_at   <= '0;
        end else if (i_cmd.advance) begin
            r_prev      <= r_at;
            r_prev_size <= rd_size;
            r_prev_used <= rd_used;
            r_at        <= next_at;
        end
        if (i_cmd.latch_cur) begin
            r_cur_size <= rd_size;
        end else if (i_cmd.merge_nx) begin
            r_cur_size <= r_cur_size + SW'(HEADER_BYTES) + rd_size;
        end
        if (i_cmd.res_we) begin
            r_res_status <= i_cmd.res_status;
            r_res_offset <= i_cmd.res_off ? OFF_W'(at_hdr) : '0;
        end
        if (i_cmd.out_load) begin
            r_out_offset <= r_res_offset;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_prev  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_has_prev <= 1'b0;
            end else if (i_cmd.advance) begin
                r_has_prev <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_offset  = r_out_offset;
    assign o_status  = r_out_status;

endmodule

FILE: rtl/core/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Controller: sequences the header walk, split, merge and result hand-off.
// ----------------------------------------------------------------------------
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    output logic o_s_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_EXAM,
        S_SPLIT,
        S_NX_RD,
        S_NX_CHK,
        S_FREE_WR,
        S_PREV_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd     = '0;
        o_cmd.res_status = ST_OK;
        o_s_ready = 1'b0;
        n_state   = r_state;
        case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.walk_end) begin
                    o_cmd.res_we = 1'b1;
                    o_cmd.res_status = i_sts.is_free ? ST_INVALID : ST_NO_SPACE;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_at = 1'b1;
                    n_state = S_EXAM;
                end
            end
            S_EXAM: begin
                o_cmd.latch_cur = 1'b1;
                if (!i_sts.is_free) begin
                    if (i_sts.fit) begin
                        o_cmd.wr_alloc = 1'b1;
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_off  = 1'b1;
                        n_state = i_sts.split ? S_SPLIT : S_DONE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state = S_READ;
                    end
                end else if (i_sts.match) begin
                    if (i_sts.cur_used) begin
                        n_state = S_NX_RD;
                    end else begin
                        o_cmd.res_we = 1'b1;
                        o_cmd.res_status = ST_INVALID;
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_READ;
                end
            end
            S_SPLIT: begin
                o_cmd.wr_split = 1'b1;
                n_state = S_DONE;
            end
            S_NX_RD: begin
                if (i_sts.nx_in) begin
                    o_cmd.rd_nx = 1'b1;
                    n_state = S_NX_CHK;
                end else begin
                    n_state = S_FREE_WR;
                end
            end
            S_NX_CHK: begin
                o_cmd.merge_nx = i_sts.nx_free;
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                o_cmd.wr_at_free = 1'b1;
                o_cmd.res_we = 1'b1;
                n_state = i_sts.prev_merge ? S_PREV_WR : S_DONE;
            end
            S_PREV_WR: begin
                o_cmd.wr_prev = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
